### sv/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg: shared definitions for the falling sand grid
// Grid geometry, cell and request codes, sequencer states.
// ----------------------------------------------------------------------------
package fsg_pkg;

    localparam int GRID_COLS = 180;
    localparam int GRID_ROWS = 160;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W    = $clog2(CELLS);

    // coordinate width: holds the grid extent and a target plus half brush
    localparam int CRD_A = $clog2(GRID_COLS + 1);
    localparam int CRD_B = $clog2(GRID_ROWS + 1);
    localparam int CRD_M = (CRD_A > CRD_B) ? CRD_A : CRD_B;
    localparam int CRD_W = (CRD_M > 9) ? CRD_M : 9;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_SAND  = 2'd1;
    localparam logic [1:0] CELL_WATER = 2'd2;

    localparam logic [1:0] REQ_PAINT = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] CFG_MATERIAL = 2'd0;
    localparam logic [1:0] CFG_SIZE     = 2'd1;
    localparam logic [1:0] CFG_SEED     = 2'd2;

    localparam logic [1:0]  RST_MATERIAL = 2'd1;
    localparam logic [6:0]  RST_SIZE     = 7'd20;
    localparam logic [15:0] RST_SEED     = 16'd1;
    localparam logic [15:0] LFSR_MASK    = 16'hB400;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAINT_SETUP,
        ST_PAINT,
        ST_READ_ISSUE,
        ST_READ_DATA,
        ST_SW_ISSUE,
        ST_SW_EVAL,
        ST_SW_NB,
        ST_SW_DECIDE,
        ST_SW_WR2,
        ST_SW_NEXT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        NB_BELOW,
        NB_RIGHT,
        NB_LEFT,
        NB_DRIGHT,
        NB_DLEFT
    } nb_t;

    localparam logic [2:0] NB_COUNT = 3'd5;

endpackage

### sv/fsg_ram.sv
// ----------------------------------------------------------------------------
// fsg_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fsg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/falling_sand_grid_step_top.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_step_top: falling sand grid with paint, step and read
// Grid of 2-bit cells in one RAM, driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// One request at a time; busy is high from acceptance until the result strobe.
// After reset a clearing pass writes all 28800 cells empty, with busy high
// (configuration writes still taken). A step visits all 28800 cells in
// descending address order: an empty, bottom-row or otherwise idle cell is
// passed over at once, while a sand or water cell above the bottom row takes
// five neighbour reads, a decision, two writes and the fetch of the next cell;
// the writes are skipped when it stays put. The result strobe done lasts one
// cycle and cannot be held off; cell_material is zero for all but reads.
module falling_sand_grid_step_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    output logic        done,
    output logic [1:0]  cell_material,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fsg_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] tgt_addr_reg, tgt_addr_next;
    logic [CRD_W-1:0]  c_reg, c_next;
    logic [CRD_W-1:0]  r_reg, r_next;
    logic [CRD_W-1:0]  r0_reg, r0_next;
    logic [CRD_W-1:0]  r1_reg, r1_next;
    logic [CRD_W-1:0]  c1_reg, c1_next;
    logic [1:0]        cur_reg, cur_next;
    logic [1:0]        nb_reg [NB_COUNT];
    logic [1:0]        nb_next [NB_COUNT];
    logic [2:0]        k_reg, k_next;
    logic [15:0]       lfsr_reg, lfsr_next;
    logic [1:0]        mat_reg;
    logic [6:0]        size_reg;
    logic              done_reg, done_next;
    logic [1:0]        cell_reg, cell_next;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [1:0]        mem_wdata, mem_rdata;

    fsg_ram #(
        .WIDTH (2),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    function automatic logic [ADDR_W-1:0] nb_addr(input logic [ADDR_W-1:0] a, input nb_t k);
        logic [ADDR_W-1:0] res;
        unique case (k)
            NB_BELOW:  res = a + ADDR_W'(1);
            NB_RIGHT:  res = a + ADDR_W'(GRID_ROWS);
            NB_LEFT:   res = a - ADDR_W'(GRID_ROWS);
            NB_DRIGHT: res = a + ADDR_W'(GRID_ROWS + 1);
            NB_DLEFT:  res = a - ADDR_W'(GRID_ROWS - 1);
            default:   res = a;
        endcase
        return res;
    endfunction

    // request decode
    logic              accept;
    logic [CRD_W-1:0]  h, colx, rowx, pc0, pc1, pr0, pr1, c1t, r1t;
    logic              paint_none, read_in;
    assign accept = start && (state_reg == ST_IDLE);
    assign h    = CRD_W'(size_reg[6:1]);
    assign colx = CRD_W'(col);
    assign rowx = CRD_W'(row);
    assign c1t  = colx + h;
    assign r1t  = rowx + h;
    assign pc0  = (colx >= h) ? colx - h : '0;
    assign pr0  = (rowx >= h) ? rowx - h : '0;
    assign pc1  = (c1t > CRD_W'(GRID_COLS)) ? CRD_W'(GRID_COLS) : c1t;
    assign pr1  = (r1t > CRD_W'(GRID_ROWS)) ? CRD_W'(GRID_ROWS) : r1t;
    assign paint_none = (mat_reg > CELL_WATER) || (pc0 >= pc1) || (pr0 >= pr1);
    assign read_in = (colx < CRD_W'(GRID_COLS)) && (rowx < CRD_W'(GRID_ROWS));

    // sweep
    logic              work, last_cell, right_in, left_in;
    logic [ADDR_W-1:0] adv_addr;
    logic [CRD_W-1:0]  adv_c, adv_r;
    logic              move, coin_used;
    nb_t               sel;
    assign work = ((mem_rdata == CELL_WATER) || (mem_rdata == CELL_SAND))
                  && (r_reg != CRD_W'(GRID_ROWS - 1));
    assign last_cell = (addr_reg == '0);
    assign adv_addr  = addr_reg - ADDR_W'(1);
    assign adv_c     = (r_reg == '0) ? c_reg - CRD_W'(1) : c_reg;
    assign adv_r     = (r_reg == '0) ? CRD_W'(GRID_ROWS - 1) : r_reg - CRD_W'(1);
    assign right_in  = (c_reg != CRD_W'(GRID_COLS - 1));
    assign left_in   = (c_reg != '0);

    always_comb
    begin
        logic wb, wr, wl, sb, sr, sdr, sdl;
        wb  = (nb_reg[NB_BELOW] == CELL_EMPTY);
        wr  = right_in && (nb_reg[NB_RIGHT] == CELL_EMPTY);
        wl  = left_in && (nb_reg[NB_LEFT] == CELL_EMPTY);
        sb  = (nb_reg[NB_BELOW] != CELL_SAND);
        sr  = right_in && (nb_reg[NB_RIGHT] != CELL_SAND);
        sdr = right_in && (nb_reg[NB_DRIGHT] != CELL_SAND);
        sdl = left_in && (nb_reg[NB_DLEFT] != CELL_SAND);
        move      = 1'b1;
        coin_used = 1'b0;
        sel       = NB_BELOW;
        if (cur_reg == CELL_WATER)
        begin
            priority if (wb)
                sel = NB_BELOW;
            else if (wr && wl)
            begin
                coin_used = 1'b1;
                sel = lfsr_reg[0] ? NB_LEFT : NB_RIGHT;
            end
            else if (wr)
                sel = NB_RIGHT;
            else if (wl)
                sel = NB_LEFT;
            else
                move = 1'b0;
        end
        else
        begin
            priority if (sb)
                sel = NB_BELOW;
            else if (sdr && sdl && sr)
            begin
                coin_used = 1'b1;
                sel = lfsr_reg[0] ? NB_DLEFT : NB_DRIGHT;
            end
            else if (sdr)
                sel = NB_DRIGHT;
            else if (sdl)
                sel = NB_DLEFT;
            else
                move = 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:       if (addr_reg == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (start)
                begin
                    priority case (req_type)
                        REQ_PAINT: state_next = paint_none ? ST_DONE : ST_PAINT_SETUP;
                        REQ_STEP:  state_next = ST_SW_ISSUE;
                        REQ_READ:  state_next = read_in ? ST_READ_ISSUE : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_PAINT_SETUP: state_next = ST_PAINT;
            ST_PAINT:
            begin
                if ((r_reg + CRD_W'(1) == r1_reg) && (c_reg + CRD_W'(1) == c1_reg))
                    state_next = ST_DONE;
            end
            ST_READ_ISSUE:  state_next = ST_READ_DATA;
            ST_READ_DATA:   state_next = ST_DONE;
            ST_SW_ISSUE:    state_next = ST_SW_EVAL;
            ST_SW_EVAL:
            begin
                if (work)
                    state_next = ST_SW_NB;
                else if (last_cell)
                    state_next = ST_DONE;
            end
            ST_SW_NB:       if (k_reg == NB_COUNT) state_next = ST_SW_DECIDE;
            ST_SW_DECIDE:   state_next = move ? ST_SW_WR2 : ST_SW_NEXT;
            ST_SW_WR2:      state_next = ST_SW_NEXT;
            ST_SW_NEXT:     state_next = last_cell ? ST_DONE : ST_SW_ISSUE;
            ST_DONE:        state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        addr_next     = addr_reg;
        base_next     = base_reg;
        tgt_addr_next = tgt_addr_reg;
        c_next        = c_reg;
        r_next        = r_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        c1_next       = c1_reg;
        cur_next      = cur_reg;
        nb_next       = nb_reg;
        k_next        = k_reg;
        lfsr_next     = lfsr_reg;
        done_next     = 1'b0;
        cell_next     = cell_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = CELL_EMPTY;
        mem_re        = 1'b0;
        mem_raddr     = addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_next = CELL_EMPTY;
                    c_next    = pc0;
                    r_next    = pr0;
                    r0_next   = pr0;
                    r1_next   = pr1;
                    c1_next   = pc1;
                    if (req_type == REQ_STEP)
                    begin
                        addr_next = ADDR_W'(CELLS - 1);
                        c_next    = CRD_W'(GRID_COLS - 1);
                        r_next    = CRD_W'(GRID_ROWS - 1);
                    end
                    else if (req_type == REQ_READ)
                    begin
                        addr_next = ADDR_W'(colx) * ADDR_W'(GRID_ROWS) + ADDR_W'(rowx);
                    end
                end
            end
            ST_PAINT_SETUP:
            begin
                base_next = ADDR_W'(c_reg) * ADDR_W'(GRID_ROWS) + ADDR_W'(r0_reg);
                addr_next = base_next;
            end
            ST_PAINT:
            begin
                mem_we    = 1'b1;
                mem_wdata = mat_reg;
                if (r_reg + CRD_W'(1) == r1_reg)
                begin
                    c_next    = c_reg + CRD_W'(1);
                    r_next    = r0_reg;
                    base_next = base_reg + ADDR_W'(GRID_ROWS);
                    addr_next = base_next;
                end
                else
                begin
                    r_next    = r_reg + CRD_W'(1);
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_READ_ISSUE:  mem_re = 1'b1;
            ST_READ_DATA:   cell_next = mem_rdata;
            ST_SW_ISSUE:    mem_re = 1'b1;
            ST_SW_EVAL:
            begin
                mem_re = 1'b1;
                if (work)
                begin
                    cur_next  = mem_rdata;
                    mem_raddr = nb_addr(addr_reg, NB_BELOW);
                    k_next    = 3'd1;
                end
                else if (!last_cell)
                begin
                    // empty or idle cell: move on and fetch the next one at once
                    addr_next = adv_addr;
                    c_next    = adv_c;
                    r_next    = adv_r;
                    mem_raddr = adv_addr;
                end
            end
            ST_SW_NB:
            begin
                nb_next[k_reg - 3'd1] = mem_rdata;
                if (k_reg != NB_COUNT)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = nb_addr(addr_reg, nb_t'(k_reg));
                    k_next    = k_reg + 3'd1;
                end
            end
            ST_SW_DECIDE:
            begin
                if (move)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = nb_reg[sel];
                    tgt_addr_next = nb_addr(addr_reg, sel);
                end
                if (coin_used)
                begin
                    lfsr_next = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LFSR_MASK : '0);
                end
            end
            ST_SW_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = tgt_addr_reg;
                mem_wdata = cur_reg;
            end
            ST_SW_NEXT:
            begin
                if (!last_cell)
                begin
                    addr_next = adv_addr;
                    c_next    = adv_c;
                    r_next    = adv_r;
                end
            end
            ST_DONE:        done_next = 1'b1;
            default:        ;
        endcase
        // seed write reloads the generator; the user must write it only while idle, the block does not enforce it
        if (cfg_valid && (cfg_index == CFG_SEED))
        begin
            lfsr_next = (cfg_data == '0) ? 16'd1 : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            lfsr_reg  <= RST_SEED;
            mat_reg   <= RST_MATERIAL;
            size_reg  <= RST_SIZE;
            done_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            lfsr_reg  <= lfsr_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
            if (cfg_valid && (cfg_index == CFG_MATERIAL))
            begin
                mat_reg <= cfg_data[1:0];
            end
            if (cfg_valid && (cfg_index == CFG_SIZE))
            begin
                size_reg <= cfg_data[6:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        tgt_addr_reg <= tgt_addr_next;
        c_reg        <= c_next;
        r_reg        <= r_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        c1_reg       <= c1_next;
        cur_reg      <= cur_next;
        nb_reg       <= nb_next;
        cell_reg     <= cell_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign cell_material = cell_reg;
    assign cfg_ready     = 1'b1;

endmodule

### sv/fsg_checker.sv
// ----------------------------------------------------------------------------
// fsg_checker: port-level checks for the falling sand grid
// Watches request, result and busy behaviour over time.
// ----------------------------------------------------------------------------
module fsg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] cell_material
);
    import fsg_pkg::*;

    // a strobe is always a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");

    // an accepted transaction raises busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after start");

    // the result goes out once the block is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");

    a_material_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cell_material != 2'd3)) else $error("illegal material code");

endmodule

bind falling_sand_grid_step_top fsg_checker u_fsg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .cell_material (cell_material)
);

### bench/falling_sand_grid_step_top_test.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_step_top_test: self-checking bench for the sand grid
// Paints, sweeps and reads the grid with directed and random transactions.
// A local grid and LFSR model predict every result and check it on the
// done strobe.
// ----------------------------------------------------------------------------
module falling_sand_grid_step_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fsg_pkg::*;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [15:0] data;
        logic [1:0]  kind;
        logic [7:0]  c;
        logic [7:0]  r;
    } txn_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        done;
    logic [1:0]  cell_material;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    falling_sand_grid_step_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .col           (col),
        .row           (row),
        .done          (done),
        .cell_material (cell_material),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // local copy of the grid and its settings
    logic [1:0]  grid_model [GRID_COLS][GRID_ROWS];
    logic [15:0] coin_state;
    logic [1:0]  paint_mat;
    logic [6:0]  paint_size;

    txn_t       pending_txns[$];
    logic [1:0] expected_cells[$];
    int         errs;
    int         n_reads, n_steps, n_paints, n_cfgs;
    bit         req_taken, cfg_taken;
    int         gap;
    int         quiet_cycles;
    bit         no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #300ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit in_bounds(int c, int r);
        return c >= 0 && c < GRID_COLS && r >= 0 && r < GRID_ROWS;
    endfunction

    function automatic bit sand_free(int c, int r);
        return in_bounds(c, r) && grid_model[c][r] != CELL_SAND;
    endfunction

    function automatic bit water_free(int c, int r);
        return in_bounds(c, r) && grid_model[c][r] == CELL_EMPTY;
    endfunction

    function automatic bit flip_coin();
        bit b;
        b = coin_state[0];
        coin_state = coin_state >> 1;
        if (b)
            coin_state = coin_state ^ LFSR_MASK;
        return b;
    endfunction

    function automatic void swap_cells(int c0, int r0, int c1, int r1);
        logic [1:0] t;
        t = grid_model[c0][r0];
        grid_model[c0][r0] = grid_model[c1][r1];
        grid_model[c1][r1] = t;
    endfunction

    function automatic void sweep_grid();
        for (int c = GRID_COLS - 1; c >= 0; c--)
        begin
            for (int r = GRID_ROWS - 1; r >= 0; r--)
            begin
                if (grid_model[c][r] == CELL_WATER && r + 1 < GRID_ROWS)
                begin
                    if (water_free(c, r + 1))
                        swap_cells(c, r, c, r + 1);
                    else if (water_free(c + 1, r) && water_free(c - 1, r))
                    begin
                        if (flip_coin() == 1'b0)
                            swap_cells(c, r, c + 1, r);
                        else
                            swap_cells(c, r, c - 1, r);
                    end
                    else if (water_free(c + 1, r))
                        swap_cells(c, r, c + 1, r);
                    else if (water_free(c - 1, r))
                        swap_cells(c, r, c - 1, r);
                end
                // sand sees whatever water left in this cell
                if (grid_model[c][r] == CELL_SAND && r + 1 < GRID_ROWS)
                begin
                    if (sand_free(c, r + 1))
                        swap_cells(c, r, c, r + 1);
                    else if (sand_free(c + 1, r + 1) && sand_free(c - 1, r + 1) &&
                             sand_free(c + 1, r))
                    begin
                        if (flip_coin() == 1'b0)
                            swap_cells(c, r, c + 1, r + 1);
                        else
                            swap_cells(c, r, c - 1, r + 1);
                    end
                    else if (sand_free(c + 1, r + 1))
                        swap_cells(c, r, c + 1, r + 1);
                    else if (sand_free(c - 1, r + 1))
                        swap_cells(c, r, c - 1, r + 1);
                end
            end
        end
    endfunction

    function automatic void paint_brush(int tc, int tr);
        int h;
        int c0, c1, r0, r1;
        h = paint_size / 2;
        c0 = tc - h;
        c1 = tc + h;
        r0 = tr - h;
        r1 = tr + h;
        if (paint_mat > CELL_WATER)
            return;
        if (c0 < 0) c0 = 0;
        if (r0 < 0) r0 = 0;
        if (c1 > GRID_COLS) c1 = GRID_COLS;
        if (r1 > GRID_ROWS) r1 = GRID_ROWS;
        for (int c = c0; c < c1; c++)
            for (int r = r0; r < r1; r++)
                grid_model[c][r] = paint_mat;
    endfunction

    function automatic logic [1:0] predict_cell(logic [1:0] kind, int c, int r);
        logic [1:0] res;
        res = CELL_EMPTY;
        if (kind == REQ_PAINT)
            paint_brush(c, r);
        else if (kind == REQ_STEP)
            sweep_grid();
        else if (kind == REQ_READ && in_bounds(c, r))
            res = grid_model[c][r];
        return res;
    endfunction

    function automatic void write_setting(logic [1:0] idx, logic [15:0] d);
        if (idx == CFG_MATERIAL)
            paint_mat = d[1:0];
        else if (idx == CFG_SIZE)
            paint_size = d[6:0];
        else if (idx == CFG_SEED)
            coin_state = (d == 16'd0) ? 16'd1 : d;
    endfunction

    task automatic add_cfg(logic [1:0] idx, logic [15:0] d);
        txn_t t;
        t = '{default: '0};
        t.is_cfg = 1'b1;
        t.idx    = idx;
        t.data   = d;
        pending_txns.push_back(t);
    endtask

    task automatic add_req(logic [1:0] kind, logic [7:0] c, logic [7:0] r);
        txn_t t;
        t = '{default: '0};
        t.kind = kind;
        t.c    = c;
        t.r    = r;
        pending_txns.push_back(t);
    endtask

    // monitor and predictor: sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_cells.size() == 0)
                begin
                    $error("unexpected result, cell_material %0d", cell_material);
                    errs++;
                end
                else
                begin
                    logic [1:0] want;
                    want = expected_cells.pop_front();
                    if (cell_material !== want)
                    begin
                        $error("cell_material expected %0d actual %0d", want, cell_material);
                        errs++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_cells.push_back(predict_cell(req_type, col, row));
                req_taken = 1'b1;
                case (req_type)
                    REQ_READ:  n_reads++;
                    REQ_STEP:  n_steps++;
                    REQ_PAINT: n_paints++;
                    default: ;
                endcase
            end
            if (cfg_valid && cfg_ready)
            begin
                write_setting(cfg_index, cfg_data);
                cfg_taken = 1'b1;
                n_cfgs++;
            end
            quiet_cycles = (expected_cells.size() == 0 && !busy) ? quiet_cycles + 1 : 0;
        end
    end

    // driver: changes inputs at the falling edge
    always @(negedge clk)
    begin
        bit   nstart, ncfg;
        txn_t head;
        nstart = start;
        ncfg   = cfg_valid;
        if (req_taken)
        begin
            nstart = 1'b0;
            req_taken = 1'b0;
        end
        if (cfg_taken)
        begin
            ncfg = 1'b0;
            cfg_taken = 1'b0;
        end
        if (rst_n && !nstart && !ncfg && pending_txns.size() > 0)
        begin
            if (gap > 0)
                gap--;
            else
            begin
                head = pending_txns[0];
                if (!head.is_cfg)
                begin
                    pending_txns.pop_front();
                    req_type <= head.kind;
                    col      <= head.c;
                    row      <= head.r;
                    nstart = 1'b1;
                end
                else if (quiet_cycles >= 8)
                begin
                    pending_txns.pop_front();
                    cfg_index <= head.idx;
                    cfg_data  <= head.data;
                    ncfg = 1'b1;
                end
                if (nstart || ncfg)
                begin
                    if (no_gaps)
                        gap = 0;
                    else if ($urandom_range(0, 9) == 0)
                        gap = $urandom_range(5, 40);
                    else
                        gap = $urandom_range(0, 2);
                end
            end
        end
        start     <= nstart;
        cfg_valid <= ncfg;
    end

    initial
    begin
        int k, tc, tr, last_c, last_r;
        errs = 0;
        n_reads = 0; n_steps = 0; n_paints = 0; n_cfgs = 0;
        req_taken = 1'b0; cfg_taken = 1'b0;
        gap = 0; quiet_cycles = 0; no_gaps = 1'b0;
        for (int c = 0; c < GRID_COLS; c++)
            for (int r = 0; r < GRID_ROWS; r++)
                grid_model[c][r] = CELL_EMPTY;
        paint_mat  = RST_MATERIAL;
        paint_size = RST_SIZE;
        coin_state = RST_SEED;
        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = REQ_PAINT;
        col       = '0;
        row       = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MATERIAL;
        cfg_data  = '0;

        // directed: corners, clipping, odd and empty brushes, odd codes
        add_req(REQ_PAINT, 8'd90, 8'd80);              // reset settings
        add_req(REQ_READ, 8'd90, 8'd80);
        add_cfg(CFG_SEED, 16'd0);                      // zero seed loads as one
        add_cfg(CFG_SIZE, 16'd5);                      // odd size
        add_req(REQ_PAINT, 8'd0, 8'd0);
        add_req(REQ_PAINT, 8'd179, 8'd159);
        add_req(REQ_READ, 8'd0, 8'd0);
        add_req(REQ_READ, 8'd179, 8'd159);
        add_req(REQ_READ, 8'd255, 8'd255);             // outside the grid
        add_req(REQ_READ, 8'd180, 8'd0);
        add_req(2'd3, 8'd255, 8'd255);                 // unknown request
        add_req(REQ_STEP, 8'd0, 8'd0);
        add_req(REQ_READ, 8'd179, 8'd158);
        add_cfg(CFG_MATERIAL, {14'd0, CELL_WATER});
        add_cfg(CFG_SIZE, 16'd64);
        add_cfg(CFG_SEED, 16'hFFFF);
        add_cfg(2'd3, 16'hFFFF);                       // unknown index
        add_req(REQ_PAINT, 8'd100, 8'd100);
        add_req(REQ_STEP, 8'd0, 8'd0);
        add_req(REQ_READ, 8'd100, 8'd131);
        add_cfg(CFG_MATERIAL, 16'd3);                  // material three paints nothing
        add_req(REQ_PAINT, 8'd100, 8'd100);
        add_cfg(CFG_MATERIAL, 16'd0);                  // erase
        add_cfg(CFG_SIZE, 16'd1);
        add_req(REQ_PAINT, 8'd100, 8'd100);
        add_cfg(CFG_SIZE, 16'd0);
        add_req(REQ_PAINT, 8'd100, 8'd100);
        add_cfg(CFG_SIZE, 16'd8);
        add_req(REQ_PAINT, 8'd100, 8'd140);
        add_req(REQ_READ, 8'd100, 8'd140);

        // random phases: new settings, a build-up of paint, sweeps and reads
        last_c = 90;
        last_r = 80;
        for (int ph = 0; ph < 5; ph++)
        begin
            add_cfg(CFG_MATERIAL, $urandom_range(0, 9) == 0 ? 16'd0 :
                    16'($urandom_range(1, 2)));
            add_cfg(CFG_SIZE, ph == 4 ? 16'd64 : 16'($urandom_range(0, 14)));
            add_cfg(CFG_SEED, 16'($urandom_range(0, 65535)));
            for (int i = 0; i < 16; i++)
            begin
                k = $urandom_range(0, 99);
                if (k < 40)
                begin
                    last_c = $urandom_range(0, 255);
                    last_r = $urandom_range(0, 99) < 80 ? $urandom_range(0, 159) :
                             $urandom_range(0, 255);
                    add_req(REQ_PAINT, 8'(last_c), 8'(last_r));
                end
                else if (k < 50)
                    add_req(REQ_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else if (k < 95)
                begin
                    // either near the last paint or near the floor
                    if ($urandom_range(0, 1))
                    begin
                        tc = last_c + $urandom_range(0, 8) - 4;
                        tr = last_r + $urandom_range(0, 8) - 4;
                    end
                    else
                    begin
                        tc = $urandom_range(0, 179);
                        tr = $urandom_range(150, 159);
                    end
                    add_req(REQ_READ, 8'(tc), 8'(tr));
                end
                else
                    add_req(2'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phases alternate between random gaps and back-to-back traffic
        while (pending_txns.size() > 0 || start || cfg_valid)
        begin
            @(posedge clk);
            if ($urandom_range(0, 499) == 0)
                no_gaps = ~no_gaps;
        end
        while (expected_cells.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d paints, %0d sweeps, %0d reads and %0d register writes",
                 n_paints, n_steps, n_reads, n_cfgs);
        if (errs == 0 && expected_cells.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
